@@ rtl/stream_substring_replace_unit_assert.svh @@
// ---------------------------------------------------------------------------
// substring replace unit assertion macros
// shared property forms for the rtl checks, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef STREAM_SUBSTRING_REPLACE_UNIT_ASSERT_SVH
`define STREAM_SUBSTRING_REPLACE_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define SRU_ASSERT(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("sru assertion failed");

// consequent holds in the same cycle as the antecedent
`define SRU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sru assertion failed");

// consequent holds in the cycle after the antecedent
`define SRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sru assertion failed");

`endif

@@ rtl/sru_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// substring replace unit package
// shared widths, register codes and the structs passed between modules
// ---------------------------------------------------------------------------
package sru_pkg;

	localparam int MAX_PATTERN_DEF = 8;
	localparam int BYTE_W          = 8;
	localparam int BURST_DEPTH     = 8;
	localparam int ITEM_W          = $clog2(BURST_DEPTH + 1);
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 64;
	localparam int LEN_FIELD_W     = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEARCH_PATTERN     = 2'd0,
		CFG_SEARCH_LENGTH      = 2'd1,
		CFG_REPLACEMENT_TEXT   = 2'd2,
		CFG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic ld;
		logic clr;
	} cell_ctrl_t;

	// results caused by one request, first result in byte 0
	typedef struct packed {
		logic [BURST_DEPTH-1:0][BYTE_W-1:0] bytes;
		logic [ITEM_W-1:0]                  n_items;
		logic                               has;
		logic                               last;
	} burst_t;

endpackage

@@ rtl/sru_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// substring replace window cell
// holds one window byte and one prefix-match bit, fed by its neighbor
// ---------------------------------------------------------------------------
module sru_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sru_pkg::cell_ctrl_t       ctrl,
	input  logic [sru_pkg::BYTE_W-1:0] in_byte,
	input  logic [sru_pkg::BYTE_W-1:0] pat_byte,
	input  logic                      prev_hit,
	input  logic [sru_pkg::BYTE_W-1:0] prev_byte,
	input  logic                      keep,
	output logic                      hit,
	output logic                      hit_q,
	output logic [sru_pkg::BYTE_W-1:0] byte_q
);
	import sru_pkg::*;

	// suffix one longer than the neighbor's still matches the pattern prefix
	assign hit = prev_hit && (in_byte == pat_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.clr) begin
			hit_q <= 1'b0;
		end else if (ctrl.ld) begin
			hit_q <= hit && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld) begin
			byte_q <= prev_byte;
		end
	end

endmodule

@@ rtl/sru_emit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// substring replace result emitter
// one staging slot and a shifter sending one result per cycle while m_tready
// ---------------------------------------------------------------------------
`include "stream_substring_replace_unit_assert.svh"

module sru_emit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  sru_pkg::burst_t            burst,
	output logic                       ready,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [sru_pkg::BYTE_W-1:0] m_tdata,
	output logic                       m_tuser,
	output logic                       m_tlast
);
	import sru_pkg::*;

	burst_t stage_q;
	logic   stage_v_q;
	burst_t ser_q;
	logic   ser_done;
	logic   load;

	assign ser_done = (ser_q.n_items == '0) ||
		((ser_q.n_items == ITEM_W'(1)) && m_tready);
	assign load  = stage_v_q && ser_done;
	assign ready = !stage_v_q || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_v_q <= 1'b0;
		end else if (push) begin
			stage_v_q <= 1'b1;
		end else if (load) begin
			stage_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			stage_q <= burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_q <= '0;
		end else if (load) begin
			ser_q <= stage_q;
		end else if (m_tvalid && m_tready) begin
			ser_q.bytes   <= ser_q.bytes >> BYTE_W;
			ser_q.n_items <= ser_q.n_items - 1'b1;
		end
	end

	assign m_tvalid = (ser_q.n_items != '0);
	assign m_tdata  = ser_q.bytes[0];
	assign m_tuser  = ser_q.has;
	assign m_tlast  = ser_q.last && (ser_q.n_items == ITEM_W'(1));

	`SRU_ASSERT_IMPL(a_emit_push_room, clk, arst_n, push, ready)
	`SRU_ASSERT_IMPL(a_emit_push_items, clk, arst_n, push, (burst.n_items != '0) && (burst.n_items <= ITEM_W'(BURST_DEPTH)))
	`SRU_ASSERT_NEXT(a_emit_load_shows, clk, arst_n, load, m_tvalid)
	`SRU_ASSERT_IMPL(a_emit_bare_alone, clk, arst_n, m_tvalid && !m_tuser, m_tlast)

endmodule

@@ rtl/stream_substring_replace_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stream substring replace unit
// rewrites a byte stream, replacing each leftmost non-overlapping match
// ---------------------------------------------------------------------------
// usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the search
//   pattern, search length, replacement text and replacement length; always
//   ready. the user must write it only while the stream is idle; the block
//   does not enforce this. writing the pattern or its length drops held bytes
//   s_* carries one source byte per request (tuser = byte present, tlast =
//   end of string); m_* returns rewritten bytes (tuser = byte present, 0 on
//   a bare end marker; tlast on the final result of the string)
//   the cell row absorbs one byte per cycle while s_tready is high; a request
//   yields zero to eight results, and the output shifter sends one result per
//   cycle while m_tready is high; once the staging slot fills, the next request
//   waits until the shifter has sent the results ahead of it. each result passes
//   the staging slot, then the output shifter. a stalled receiver fills the
//   output shifter, then the staging slot, then s_tready drops; nothing is lost
//   or reordered. reset clears the registers to zero (pass-through), the window
//   and the output path
// ---------------------------------------------------------------------------
`include "stream_substring_replace_unit_assert.svh"

module stream_substring_replace_unit #(
	parameter int MAX_PATTERN = sru_pkg::MAX_PATTERN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sru_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sru_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sru_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
	input  logic                          s_tuser,   // [0] in_has_byte
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sru_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
	output logic                          m_tuser,   // [0] out_has_byte
	output logic                          m_tlast
);
	import sru_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	// configuration
	logic                                 cfg_wr;
	logic                                 clr_search;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0]   pat_q;
	logic [BURST_DEPTH-1:0][BYTE_W-1:0]   repl_q;
	logic [LEN_W-1:0]                     slen_q;
	logic [ITEM_W-1:0]                    rlen_q;

	// request fields
	logic              accept;
	logic [BYTE_W-1:0] in_byte;
	logic              in_has_byte;
	logic              in_last;

	// window cells
	cell_ctrl_t                         cell_ctrl;
	logic [MAX_PATTERN-1:0]             hit;
	logic [MAX_PATTERN-1:0]             hit_q;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_q;
	logic [MAX_PATTERN-1:0]             keep;
	logic [MAX_PATTERN-1:0]             is_end;
	logic [MAX_PATTERN-1:0]             cell_keep;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] cand;
	logic [LEN_W-1:0]                   cnt_q;
	logic [LEN_W-1:0]                   cnt_next;
	logic [LEN_W-1:0]                   fill;
	logic                               pass;
	logic                               match;

	// results of this request
	logic [ITEM_W-1:0] n_bytes;
	logic              bare;
	burst_t            burst;
	logic              push;
	logic              emit_ready;

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign clr_search = cfg_wr && ((cfg_index == CFG_SEARCH_PATTERN) ||
		(cfg_index == CFG_SEARCH_LENGTH));

	// lengths are stored already clamped to what the hardware holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			slen_q <= '0;
			repl_q <= '0;
			rlen_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SEARCH_PATTERN: begin
					pat_q <= cfg_data[MAX_PATTERN*BYTE_W-1:0];
				end
				CFG_SEARCH_LENGTH: begin
					if (cfg_data[LEN_FIELD_W-1:0] > LEN_FIELD_W'(MAX_PATTERN)) begin
						slen_q <= LEN_W'(MAX_PATTERN);
					end else begin
						slen_q <= LEN_W'(cfg_data[LEN_FIELD_W-1:0]);
					end
				end
				CFG_REPLACEMENT_TEXT: begin
					repl_q <= cfg_data[BURST_DEPTH*BYTE_W-1:0];
				end
				CFG_REPLACEMENT_LENGTH: begin
					if (cfg_data[LEN_FIELD_W-1:0] > LEN_FIELD_W'(BURST_DEPTH)) begin
						rlen_q <= ITEM_W'(BURST_DEPTH);
					end else begin
						rlen_q <= ITEM_W'(cfg_data[LEN_FIELD_W-1:0]);
					end
				end
			endcase
		end
	end

	assign in_byte     = s_tdata;
	assign in_has_byte = s_tuser;
	assign in_last     = s_tlast;
	assign s_tready    = emit_ready;
	assign accept      = s_tvalid && s_tready;

	// cell j keeps a hit only for a proper prefix (j+1 < len); cell len-1
	// hitting means the whole pattern ended on this byte
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			keep[j]   = (j + 1) < int'(slen_q);
			is_end[j] = (j + 1) == int'(slen_q);
		end
	end

	assign pass      = (slen_q == '0);
	assign match     = in_has_byte && (|(hit & is_end));
	// a match or end of string restarts the scan with an empty window
	assign cell_keep = (match || in_last) ? '0 : keep;

	assign cell_ctrl.ld  = accept && (in_has_byte || in_last);
	assign cell_ctrl.clr = clr_search;

	// row of cells: cell 0 takes the new byte, each cell hands its byte and
	// hit bit to the next; hit bit j means the last j+1 bytes match the
	// first j+1 pattern bytes
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic              prev_hit;
		logic [BYTE_W-1:0] prev_byte;
		if (j == 0) begin : g_head
			assign prev_hit  = 1'b1;
			assign prev_byte = in_byte;
		end else begin : g_link
			assign prev_hit  = hit_q[j-1];
			assign prev_byte = win_q[j-1];
		end
		sru_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.in_byte   (in_byte),
			.pat_byte  (pat_q[j]),
			.prev_hit  (prev_hit),
			.prev_byte (prev_byte),
			.keep      (cell_keep[j]),
			.hit       (hit[j]),
			.hit_q     (hit_q[j]),
			.byte_q    (win_q[j])
		);
	end

	// held bytes after this request: longest suffix still a proper prefix
	always_comb begin
		cnt_next = '0;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if (hit[j] && cell_keep[j]) begin
				cnt_next = LEN_W'(j + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clr_search) begin
			cnt_q <= '0;
		end else if (cell_ctrl.ld) begin
			cnt_q <= cnt_next;
		end
	end

	// candidate bytes newest first: the new byte ahead of the window
	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (k == 0) begin
				cand[k] = in_has_byte ? in_byte : win_q[0];
			end else begin
				cand[k] = in_has_byte ? win_q[k-1] : win_q[k];
			end
		end
	end

	assign fill = cnt_q + LEN_W'(in_has_byte);

	// how many bytes leave: none without byte or end, replacement on a match,
	// everything on end of string or pass-through, otherwise the oldest bytes
	// that can no longer start a match
	always_comb begin
		if (!in_has_byte && !in_last) begin
			n_bytes = '0;
		end else if (match) begin
			n_bytes = rlen_q;
		end else if (in_last || pass) begin
			n_bytes = ITEM_W'(fill);
		end else begin
			n_bytes = ITEM_W'(fill - cnt_next);
		end
	end

	assign bare = in_last && (n_bytes == '0);

	// oldest byte goes first: result i is candidate fill-1-i; a bare end
	// marker after an empty replacement carries a zero byte
	always_comb begin
		burst.bytes = '0;
		if (match && !bare) begin
			burst.bytes = repl_q;
		end else if (!match) begin
			for (int i = 0; i < BURST_DEPTH; i++) begin
				for (int k = 0; k < MAX_PATTERN; k++) begin
					if (i + k + 1 == int'(fill)) begin
						burst.bytes[i] = cand[k];
					end
				end
			end
		end
		burst.n_items = bare ? ITEM_W'(1) : n_bytes;
		burst.has     = !bare;
		burst.last    = in_last;
	end

	assign push = accept && (burst.n_items != '0);

	sru_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.burst    (burst),
		.ready    (emit_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`SRU_ASSERT(a_top_cnt_range, clk, arst_n, cnt_q < LEN_W'(MAX_PATTERN))
	`SRU_ASSERT_IMPL(a_top_pass_empty, clk, arst_n, pass, cnt_q == '0)
	`SRU_ASSERT(a_top_tail_cell_idle, clk, arst_n, !hit_q[MAX_PATTERN-1])
	`SRU_ASSERT_NEXT(a_top_match_clears, clk, arst_n, accept && match, cnt_q == '0)

endmodule

@@ bench/tb_stream_substring_replace_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stream substring replace unit testbench
// drives byte strings through the unit under several search and replacement
// settings, predicts every rewritten byte and end marker, and compares each
// result field by field in order, with random idling on both stream sides
// ---------------------------------------------------------------------------
module tb_stream_substring_replace_unit;

	import sru_pkg::*;

	localparam int SETTLE_CYCLES   = 8;       // first result passes the staging slot and the output shifter
	localparam int TAIL_CYCLES     = 16;
	localparam int DRAIN_CYCLES    = 20000;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 25;
	localparam int IDLE_PCT        = 16;
	localparam int PRINT_CAP       = 60;
	localparam longint LIMIT_NS    = 400000;

	// one rewritten result, as it leaves on the master side
	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
	} text_result_t;

	typedef enum logic {
		ROW_WRITE,
		ROW_ITEM
	} row_kind_t;

	// one row of the directed table: a register write or a source request,
	// with a typed-in result where it is obvious
	typedef struct packed {
		row_kind_t    kind;
		cfg_reg_t     reg_idx;
		logic [63:0]  value;
		logic [7:0]   in_b;
		logic         in_has;
		logic         in_last;
		logic         typed;
		text_result_t typed_res;
	} stim_row_t;

	localparam int DIR_ROWS = 37;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_reg_t    cfg_index;
	logic [63:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	// register copies and the held window of the predictor
	logic [63:0] search_pat;
	logic [3:0]  search_len;
	logic [63:0] repl_text;
	logic [3:0]  repl_len;
	logic [7:0]  held_win [0:7];
	int          held_cnt;

	text_result_t rewritten_q [$];
	int           mismatch_count;
	int           idle_pct;
	logic [7:0]   phase_base;

	stim_row_t directed_rows [0:DIR_ROWS-1] = '{
		// after reset the unit passes bytes through
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h00, 1'b1, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'hFF, 1'b1, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}},
		// empty end of string gives a bare end marker
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'hA5, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
		// no byte and not last: ignored
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h3C, 1'b0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h5A, 1'b1, 1'b1, 1'b1, '{8'h5A, 1'b1, 1'b1}},
		// "ab" -> "XYZ"
		'{ROW_WRITE, CFG_SEARCH_PATTERN,     64'h6261,   8'h0, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, CFG_SEARCH_LENGTH,      64'd2,      8'h0, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, CFG_REPLACEMENT_TEXT,   64'h5A5958, 8'h0, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, CFG_REPLACEMENT_LENGTH, 64'd3,      8'h0, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h78, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h61, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h62, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h61, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h61, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h63, 1'b1, 1'b1, 1'b0, '0},
		// oversized lengths count as eight, zero bytes are ordinary data
		'{ROW_WRITE, CFG_SEARCH_PATTERN,     64'h0,  8'h0, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, CFG_SEARCH_LENGTH,      64'd15, 8'h0, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, CFG_REPLACEMENT_TEXT,   64'h8877_6655_4433_2211, 8'h0, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, CFG_REPLACEMENT_LENGTH, 64'd12, 8'h0, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0, '0},
		// a held byte flushed by an empty end
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h00, 1'b0, 1'b1, 1'b0, '0},
		// held byte dropped by a new pattern, end gives a bare marker
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_WRITE, CFG_SEARCH_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF, 8'h0, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
		// held byte dropped by a new length
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'hFF, 1'b1, 1'b0, 1'b0, '0},
		'{ROW_WRITE, CFG_SEARCH_LENGTH,  64'd8, 8'h0, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
		// empty replacement, a held byte flushed at the end of its string
		'{ROW_WRITE, CFG_REPLACEMENT_LENGTH, 64'd0, 8'h0, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  CFG_SEARCH_PATTERN, 64'h0, 8'hFF, 1'b1, 1'b1, 1'b0, '0}
	};

	stream_substring_replace_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [7:0] in_byte
		.s_tuser   (s_tuser),   // [0] in_has_byte
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [7:0] out_byte
		.m_tuser   (m_tuser),   // [0] out_has_byte
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#(LIMIT_NS);
		$display("FAILED: results differ");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// register write seen by the predictor; search changes drop held bytes
	function automatic void apply_register(input cfg_reg_t idx, input logic [63:0] val);
		case (idx)
			CFG_SEARCH_PATTERN: begin
				search_pat = val;
				held_cnt   = 0;
			end
			CFG_SEARCH_LENGTH: begin
				search_len = val[3:0];
				held_cnt   = 0;
			end
			CFG_REPLACEMENT_TEXT:   repl_text = val;
			CFG_REPLACEMENT_LENGTH: repl_len  = val[3:0];
			default: ;
		endcase
	endfunction

	// rewrites one source request and queues the results it causes
	function automatic void predict_rewrite(input logic [7:0] b, input logic h, input logic l,
			input logic typed, input text_result_t typed_res);
		logic [7:0]   hold [0:8];
		text_result_t outs [$];
		int           cnt;
		int           len;
		int           rl;
		logic         full;
		logic         pre;
		len = (search_len > 4'd8) ? 8 : int'(search_len);
		rl  = (repl_len > 4'd8) ? 8 : int'(repl_len);
		cnt = held_cnt;
		for (int i = 0; i < 8; i++)
			hold[i] = held_win[i];
		hold[8] = 8'h00;
		if (h) begin
			if (len == 0) begin
				outs.push_back('{b, 1'b1, 1'b0});
			end else begin
				hold[cnt] = b;
				cnt++;
				if (cnt == len) begin
					full = 1'b1;
					for (int i = 0; i < len; i++)
						if (hold[i] != search_pat[i*8 +: 8])
							full = 1'b0;
					if (full) begin
						for (int i = 0; i < rl; i++)
							outs.push_back('{repl_text[i*8 +: 8], 1'b1, 1'b0});
						cnt = 0;
					end
				end
				// release leading bytes until the rest is a proper prefix
				while (cnt > 0) begin
					pre = (cnt < len);
					for (int i = 0; i < cnt; i++)
						if (hold[i] != search_pat[i*8 +: 8])
							pre = 1'b0;
					if (pre)
						break;
					outs.push_back('{hold[0], 1'b1, 1'b0});
					for (int i = 0; i < cnt - 1; i++)
						hold[i] = hold[i+1];
					cnt--;
				end
			end
		end
		if (l) begin
			for (int i = 0; i < cnt; i++)
				outs.push_back('{hold[i], 1'b1, 1'b0});
			cnt = 0;
			if (outs.size() == 0)
				outs.push_back('{8'h00, 1'b0, 1'b0});
		end
		while (outs.size() > 8)
			void'(outs.pop_back());
		if (l)
			outs[outs.size()-1].last = 1'b1;
		for (int i = 0; i < 8; i++)
			held_win[i] = hold[i];
		held_cnt = cnt;
		if (typed) begin
			rewritten_q.push_back(typed_res);
		end else begin
			foreach (outs[i])
				rewritten_q.push_back(outs[i]);
		end
	endfunction

	// one source request, with a random gap ahead of it
	task automatic push_request(input logic [7:0] b, input logic h, input logic l,
			input logic typed, input text_result_t typed_res);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= h;
		s_tlast  <= l;
		do
			@(posedge clk);
		while (!s_tready);
		predict_rewrite(b, h, l, typed, typed_res);
	endtask

	// register write once the stream is quiet
	task automatic write_register(input cfg_reg_t idx, input logic [63:0] val);
		s_tvalid <= 1'b0;
		while (rewritten_q.size() != 0)
			@(posedge clk);
		// a request that only filled the window shows nothing on the output
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_register(idx, val);
	endtask

	// random text for one phase: mostly pattern copies and near misses
	task automatic feed_phase(input int n_items);
		logic [7:0] inject_q [$];
		int         sent;
		int         r;
		int         k;
		int         len;
		logic [7:0] b;
		sent = 0;
		len  = (search_len > 4'd8) ? 8 : int'(search_len);
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 4) begin
				// ignored request, not counted
				push_request(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
			end else if (r < 7) begin
				push_request(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
				sent++;
			end else begin
				if (inject_q.size() == 0) begin
					k = $urandom_range(99);
					if (len > 0 && k < 40) begin
						for (int i = 0; i < len; i++)
							inject_q.push_back(search_pat[i*8 +: 8]);
					end else if (len > 1 && k < 55) begin
						r = $urandom_range(1, len - 1);
						for (int i = 0; i < r; i++)
							inject_q.push_back(search_pat[i*8 +: 8]);
					end else if (k < 75 && len > 0) begin
						inject_q.push_back(search_pat[$urandom_range(len - 1)*8 +: 8]);
					end else if (k < 88) begin
						inject_q.push_back(phase_base + 8'($urandom_range(2)));
					end else begin
						inject_q.push_back(8'($urandom_range(255)));
					end
				end
				b = inject_q.pop_front();
				push_request(b, 1'b1, ($urandom_range(99) < 8), 1'b0, '0);
				sent++;
			end
		end
	endtask

	// receiver: random backpressure
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		text_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (rewritten_q.size() == 0) begin
				report_mismatch("result with nothing expected", 32'(m_tdata), 32'(0));
			end else begin
				want = rewritten_q.pop_front();
				if (m_tdata !== want.data)
					report_mismatch("out_byte", 32'(m_tdata), 32'(want.data));
				if (m_tuser !== want.has)
					report_mismatch("out_has_byte", 32'(m_tuser), 32'(want.has));
				if (m_tlast !== want.last)
					report_mismatch("out_last", 32'(m_tlast), 32'(want.last));
			end
		end
	end

	initial begin : stimulus
		logic [63:0] pat;
		logic [3:0]  slen;
		logic [3:0]  rlen;
		logic        wide;
		int          k;
		arst_n         <= 1'b0;
		cfg_valid      <= 1'b0;
		cfg_index      <= CFG_SEARCH_PATTERN;
		cfg_data       <= '0;
		s_tvalid       <= 1'b0;
		s_tdata        <= '0;
		s_tuser        <= 1'b0;
		s_tlast        <= 1'b0;
		search_pat     = '0;
		search_len     = '0;
		repl_text      = '0;
		repl_len       = '0;
		held_cnt       = 0;
		mismatch_count = 0;
		idle_pct       = IDLE_PCT;
		phase_base     = 8'h61;
		for (int i = 0; i < 8; i++)
			held_win[i] = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (directed_rows[i].kind == ROW_WRITE)
				write_register(directed_rows[i].reg_idx, directed_rows[i].value);
			else
				push_request(directed_rows[i].in_b, directed_rows[i].in_has,
					directed_rows[i].in_last, directed_rows[i].typed,
					directed_rows[i].typed_res);
		end

		// random phases, the first four at the length extremes
		for (int ph = 0; ph < PHASES; ph++) begin
			wide       = 1'($urandom_range(1));
			phase_base = 8'($urandom_range(255));
			for (int j = 0; j < 8; j++)
				pat[j*8 +: 8] = wide ? 8'($urandom_range(255))
					: phase_base + 8'($urandom_range(2));
			case (ph)
				0: begin slen = 4'd0;  rlen = 4'($urandom_range(15)); end
				1: begin slen = 4'd8;  rlen = 4'd0;  end
				2: begin slen = 4'd1;  rlen = 4'd8;  end
				3: begin slen = 4'd15; rlen = 4'd15; end
				default: begin
					slen = 4'($urandom_range(15));
					rlen = 4'($urandom_range(15));
				end
			endcase
			// later phases may keep some registers, and with them held bytes
			if (ph < 4 || $urandom_range(3) != 0)
				write_register(CFG_SEARCH_PATTERN, pat);
			if (ph < 4 || $urandom_range(3) != 0)
				write_register(CFG_SEARCH_LENGTH, {60'd0, slen});
			if (ph < 4 || $urandom_range(3) != 0)
				write_register(CFG_REPLACEMENT_TEXT, {$urandom, $urandom});
			if (ph < 4 || $urandom_range(3) != 0)
				write_register(CFG_REPLACEMENT_LENGTH, {60'd0, rlen});
			// two phases run without any idling
			idle_pct = (ph == 6 || ph == 7) ? 0 : IDLE_PCT;
			feed_phase(ITEMS_PER_PHASE);
		end

		s_tvalid <= 1'b0;
		k = 0;
		while (rewritten_q.size() != 0 && k < DRAIN_CYCLES) begin
			@(posedge clk);
			k++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (rewritten_q.size() != 0)
			report_mismatch("results never arrived", rewritten_q.size(), 32'(0));
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
